[design/hts_pkg.sv]
// Shared constants and sine table generator for the harmonic tone synthesizer.
`default_nettype none

package hts_pkg;

  // Field widths of the request and result items
  localparam int STEP_W = 31;
  localparam int AMP_W  = 16;
  localparam int LEN_W  = 24;
  localparam int PCM_W  = 16;

  // Magnitude of the weighted sum; every Q1.15 scaling keeps it in range
  localparam int MAG_W  = 31;
  localparam int FRAC_W = 15;

  // Quotient bits produced by the envelope divider
  localparam int DIV_STEPS = 15;

  // Q15 constants
  localparam logic [AMP_W-1:0] Q15_ONE  = 16'd32768;
  localparam logic [AMP_W-1:0] HEADROOM = 16'd26214;
  localparam logic signed [31:0] W_SECOND = 32'sd9830;
  localparam logic signed [31:0] W_THIRD  = 32'sd3277;

  // Q30 constants for the table build
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(x) for x in [0, pi/2], Q30 in and out, Taylor series to x^11
  function automatic logic [63:0] sin_q30(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  // One table entry from a folded angle and the lower-half flag
  function automatic logic signed [PCM_W-1:0] sine_entry(input logic [63:0] x,
                                                         input logic        neg);
    logic [63:0] s;
    logic [63:0] v;
    s = sin_q30(x);
    v = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return neg ? PCM_W'(64'd0 - v) : PCM_W'(v);
  endfunction

endpackage

`default_nettype wire

[design/harmonic_tone_synth_envelope.sv]
// Top level: request intake, phase accumulators, sequencer and output register.
`default_nettype none

// Harmonic tone synthesizer: one signed 16-bit PCM sample per request transfer.
// The fundamental and the second and third harmonics are read in turn from one
// registered sine table port, weighted 1, 0.3 and 0.1, and the magnitude is then
// scaled by note amplitude, master volume, the linear envelope and 0.8 through
// one radix-4 serial multiplier in four passes. The envelope
// divider runs one quotient bit per cycle beside the table reads and finishes
// before it is needed. A request is taken only while no other is at work; the
// block is ready for the next one in the cycle after a sample enters the output
// register, which happens only once the output side is free; a finished sample
// waits in the output register while the next request is already at work.
// master_volume may be written at any time the block is idle; values above one
// are clamped to one. The fundamental phase runs on across notes; note_start
// reloads both harmonic phases from it and restarts the envelope.
module harmonic_tone_synth_envelope #(
  parameter int PHASE_BITS       = 32,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int LENGTH_BITS      = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // freq_step[30:0], note_amplitude[46:31],
                                           // note_length[70:47], zero pad[71]
  input  wire logic [0:0]  s_axis_tuser,   // note_start[0]
  // sample stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // pcm_sample[15:0]
  output logic [0:0]       m_axis_tuser,   // clipped[0]
  // master volume write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int PROD_W  = PHASE_BITS + ADDR_W + 1;
  localparam int MAG_W   = hts_pkg::MAG_W;
  localparam int AMP_W   = hts_pkg::AMP_W;
  localparam int PCM_W   = hts_pkg::PCM_W;
  localparam logic [2:0] RD_LAST = 3'd4;
  localparam logic [LENGTH_BITS-1:0] IDX_MAX = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    MUL_AMP,
    MUL_VOL,
    MUL_ENV,
    MUL_HEAD
  } mul_sel_e;

  // request fields
  logic [hts_pkg::STEP_W-1:0] req_step;
  logic [AMP_W-1:0]           req_amp;
  logic [hts_pkg::LEN_W-1:0]  req_len;
  logic                       req_start;
  logic                       in_xfer;

  assign req_step  = s_axis_tdata[30:0];
  assign req_amp   = s_axis_tdata[46:31];
  assign req_len   = s_axis_tdata[70:47];
  assign req_start = s_axis_tuser[0];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  state_e                    state_q;
  mul_sel_e                  mi_q;
  logic [2:0]                rc_q;
  logic                      mul_wait_q;
  logic [AMP_W-1:0]          vol_q;
  logic [PHASE_BITS-1:0]     step_q;
  logic [AMP_W-1:0]          amp_q;
  logic [hts_pkg::LEN_W-1:0] len_q;
  logic [PHASE_BITS-1:0]     fund_q;
  logic [PHASE_BITS-1:0]     sec_q;
  logic [PHASE_BITS-1:0]     thd_q;
  logic [LENGTH_BITS-1:0]    idx_q;
  logic [ADDR_W-1:0]         addr_q;
  logic signed [31:0]        acc_q;
  logic [MAG_W-1:0]          mag_q;
  logic                      out_valid_q;
  logic [PCM_W-1:0]          out_pcm_q;
  logic                      out_clip_q;

  // table address: (phase * depth) >> PHASE_BITS
  logic [PHASE_BITS-1:0] phase_sel;
  logic [PROD_W-1:0]     addr_prod;

  always_comb begin
    case (rc_q)
      3'd0:    phase_sel = fund_q;
      3'd1:    phase_sel = sec_q;
      default: phase_sel = thd_q;
    endcase
  end

  assign addr_prod = PROD_W'(phase_sel) * PROD_W'(SINE_TABLE_DEPTH);

  logic signed [PCM_W-1:0] rom_data;

  hts_sine_rom #(
    .DEPTH  (SINE_TABLE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (addr_q),
    .data_o (rom_data)
  );

  // harmonic weighting
  logic signed [31:0] rom_ext;
  logic signed [31:0] weight;
  logic signed [31:0] wprod;

  assign rom_ext = 32'(rom_data);
  assign weight  = (rc_q == RD_LAST) ? hts_pkg::W_THIRD : hts_pkg::W_SECOND;
  assign wprod   = rom_ext * weight;

  // phase advance by step, 2*step and 3*step
  logic [PHASE_BITS-1:0] step2;
  logic [PHASE_BITS-1:0] step3;

  assign step2 = step_q << 1;
  assign step3 = step2 + step_q;

  // envelope
  logic             env_start;
  logic             env_valid;
  logic [AMP_W-1:0] env_val;

  assign env_start = (state_q == ST_READ) && (rc_q == '0);

  hts_env_div #(
    .IDX_W (LENGTH_BITS)
  ) u_env (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (env_start),
    .index_i  (idx_q),
    .length_i (len_q),
    .valid_o  (env_valid),
    .env_o    (env_val)
  );

  // serial scaling chain
  logic             neg;
  logic [31:0]      acc_abs;
  logic [MAG_W-1:0] mul_a;
  logic [AMP_W-1:0] mul_b;
  logic             mul_start;
  logic             mul_done;
  logic [MAG_W-1:0] mul_p;

  assign neg     = acc_q[31];
  assign acc_abs = neg ? (32'd0 - 32'(acc_q)) : 32'(acc_q);
  assign mul_a   = (mi_q == MUL_AMP) ? acc_abs[MAG_W-1:0] : mag_q;

  always_comb begin
    case (mi_q)
      MUL_AMP:  mul_b = amp_q;
      MUL_VOL:  mul_b = vol_q;
      MUL_ENV:  mul_b = env_val;
      MUL_HEAD: mul_b = hts_pkg::HEADROOM;
      default:  mul_b = '0;
    endcase
  end

  assign mul_start = (state_q == ST_MUL) && !mul_wait_q &&
                     ((mi_q != MUL_ENV) || env_valid);

  hts_ser_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // final shift and saturation
  logic [PCM_W-1:0] res;
  logic             clip;
  logic [PCM_W-1:0] sat;
  logic [PCM_W-1:0] pcm;
  logic             out_free;

  assign res  = mag_q[hts_pkg::FRAC_W +: PCM_W];
  assign clip = neg ? (res > hts_pkg::Q15_ONE) : (res > (hts_pkg::Q15_ONE - 1'b1));
  assign sat  = clip ? (neg ? hts_pkg::Q15_ONE : (hts_pkg::Q15_ONE - 1'b1)) : res;
  assign pcm  = neg ? (PCM_W'(0) - sat) : sat;
  assign out_free = !out_valid_q || m_axis_tready;

  // sequencer, voice state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mi_q        <= MUL_AMP;
      rc_q        <= '0;
      mul_wait_q  <= 1'b0;
      vol_q       <= hts_pkg::Q15_ONE;
      step_q      <= '0;
      amp_q       <= '0;
      len_q       <= '0;
      fund_q      <= '0;
      sec_q       <= '0;
      thd_q       <= '0;
      idx_q       <= '0;
      addr_q      <= '0;
      acc_q       <= '0;
      mag_q       <= '0;
      out_valid_q <= 1'b0;
      out_pcm_q   <= '0;
      out_clip_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vol_q <= (cfg_data_i > hts_pkg::Q15_ONE) ? hts_pkg::Q15_ONE : cfg_data_i;
      end

      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            step_q <= PHASE_BITS'(req_step);
            amp_q  <= (req_amp > hts_pkg::Q15_ONE) ? hts_pkg::Q15_ONE : req_amp;
            len_q  <= req_len;
            if (req_start) begin
              idx_q <= '0;
              sec_q <= fund_q;
              thd_q <= fund_q;
            end
            rc_q    <= '0;
            state_q <= ST_READ;
          end
        end

        ST_READ: begin
          addr_q <= addr_prod[PHASE_BITS +: ADDR_W];
          rc_q   <= rc_q + 1'b1;
          if (rc_q == 3'd2) begin
            acc_q <= rom_ext <<< hts_pkg::FRAC_W;
          end else if (rc_q > 3'd2) begin
            acc_q <= acc_q + wprod;
          end
          if (rc_q == RD_LAST) begin
            fund_q <= fund_q + step_q;
            sec_q  <= sec_q + step2;
            thd_q  <= thd_q + step3;
            if (idx_q != IDX_MAX) begin
              idx_q <= idx_q + 1'b1;
            end
            mi_q       <= MUL_AMP;
            mul_wait_q <= 1'b0;
            state_q    <= ST_MUL;
          end
        end

        ST_MUL: begin
          if (mul_start) begin
            mul_wait_q <= 1'b1;
          end
          if (mul_done) begin
            mag_q      <= mul_p;
            mul_wait_q <= 1'b0;
            case (mi_q)
              MUL_AMP:  mi_q <= MUL_VOL;
              MUL_VOL:  mi_q <= MUL_ENV;
              MUL_ENV:  mi_q <= MUL_HEAD;
              MUL_HEAD: state_q <= ST_FIN;
              default:  mi_q <= MUL_AMP;
            endcase
          end
        end

        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pcm_q   <= pcm;
            out_clip_q  <= clip;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pcm_q;
  assign m_axis_tuser  = out_clip_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

[design/hts_sine_rom.sv]
// Sine lookup table built at elaboration, registered read port.
`default_nettype none

module hts_sine_rom #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  wire logic                               clk_i,
  input  wire logic [ADDR_W-1:0]                  addr_i,
  output logic signed [hts_pkg::PCM_W-1:0]        data_o
);

  logic signed [hts_pkg::PCM_W-1:0] rom_w [DEPTH];

  // entry k = round(32767 * sin(2*pi*k/DEPTH)) with quadrant folding
  for (genvar k = 0; k < DEPTH; k++) begin : g_entry
    localparam logic [63:0] QTR = 64'((4 * k) / DEPTH);
    localparam logic [63:0] REM = 64'((4 * k) % DEPTH);
    localparam logic [63:0] X   = (REM * hts_pkg::HALF_PI_Q30) / 64'(DEPTH);
    assign rom_w[k] = hts_pkg::sine_entry(QTR[0] ? (hts_pkg::HALF_PI_Q30 - X) : X,
                                          QTR[1]);
  end

  // registered read
  always_ff @(posedge clk_i) begin
    data_o <= rom_w[addr_i];
  end

endmodule

`default_nettype wire

[design/hts_ser_mul.sv]
// Radix-4 digit-serial multiplier, returns (a * b) >> 15.
`default_nettype none

module hts_ser_mul (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [hts_pkg::MAG_W-1:0]   a_i,
  input  wire logic [hts_pkg::AMP_W-1:0]   b_i,
  output logic                             done_o,
  output logic [hts_pkg::MAG_W-1:0]        p_o
);

  localparam int ACC_W  = hts_pkg::MAG_W + hts_pkg::AMP_W;
  localparam int PP_W   = hts_pkg::MAG_W + 2;
  localparam int STEPS  = hts_pkg::AMP_W / 2;
  localparam int CNT_W  = $clog2(STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [hts_pkg::MAG_W-1:0] a_q;
  logic [PP_W-1:0]           a3_q;
  logic [hts_pkg::AMP_W-1:0] b_q;
  logic [ACC_W-1:0]          acc_q;
  logic [CNT_W-1:0]          cnt_q;
  logic                      run_q;
  logic                      done_q;
  logic [PP_W-1:0]           pp;

  // partial product for the top digit of b
  always_comb begin
    case (b_q[hts_pkg::AMP_W-1 -: 2])
      2'd0:    pp = '0;
      2'd1:    pp = PP_W'(a_q);
      2'd2:    pp = PP_W'(a_q) << 1;
      2'd3:    pp = a3_q;
      default: pp = '0;
    endcase
  end

  // MSB-first shift and add, two bits of b per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      a3_q   <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q   <= a_i;
        a3_q  <= PP_W'(a_i) + (PP_W'(a_i) << 1);
        b_q   <= b_i;
        acc_q <= '0;
        cnt_q <= '0;
        run_q <= 1'b1;
      end else if (run_q) begin
        acc_q <= (acc_q << 2) + ACC_W'(pp);
        b_q   <= b_q << 2;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q[hts_pkg::FRAC_W +: hts_pkg::MAG_W];

endmodule

`default_nettype wire

[design/hts_env_div.sv]
// Linear attack/decay envelope with a bit-serial restoring divider.
`default_nettype none

module hts_env_div #(
  parameter int IDX_W = 24
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [IDX_W-1:0]            index_i,
  input  wire logic [hts_pkg::LEN_W-1:0]   length_i,
  output logic                             valid_o,
  output logic [hts_pkg::AMP_W-1:0]        env_o
);

  localparam int EW    = (IDX_W > hts_pkg::LEN_W) ? IDX_W : hts_pkg::LEN_W;
  localparam int CW    = EW + 4;
  localparam int CNT_W = $clog2(hts_pkg::DIV_STEPS);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(hts_pkg::DIV_STEPS - 1);

  logic [EW-1:0] i_e;
  logic [EW-1:0] n_e;
  logic [EW-1:0] diff;
  logic [CW-1:0] ten_i;
  logic [CW-1:0] ten_d;
  logic [CW-1:0] nine_n;

  logic [EW-1:0]                 n_q;
  logic [EW-1:0]                 rem_q;
  logic [hts_pkg::DIV_STEPS-1:0] quo_q;
  logic [CNT_W-1:0]              cnt_q;
  logic                          run_q;
  logic                          valid_q;
  logic [hts_pkg::AMP_W-1:0]     env_q;
  logic [EW:0]                   rem2;
  logic                          fits;

  // setup compares: 10*i against n and 9*n
  assign i_e    = EW'(index_i);
  assign n_e    = EW'(length_i);
  assign diff   = n_e - i_e;
  assign ten_i  = (CW'(i_e) << 3) + (CW'(i_e) << 1);
  assign ten_d  = (CW'(diff) << 3) + (CW'(diff) << 1);
  assign nine_n = (CW'(n_e) << 3) + CW'(n_e);

  // one quotient bit per cycle
  assign rem2 = {rem_q, 1'b0};
  assign fits = rem2 >= {1'b0, n_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q     <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      cnt_q   <= '0;
      run_q   <= 1'b0;
      valid_q <= 1'b0;
      env_q   <= '0;
    end else if (start_i) begin
      n_q     <= n_e;
      quo_q   <= '0;
      cnt_q   <= '0;
      run_q   <= 1'b0;
      valid_q <= 1'b0;
      if (n_e == '0) begin
        env_q   <= '0;
        valid_q <= 1'b1;
      end else if (ten_i < CW'(n_e)) begin
        // attack
        rem_q <= EW'(ten_i);
        run_q <= 1'b1;
      end else if (ten_i > nine_n) begin
        if (i_e >= n_e) begin
          env_q   <= '0;
          valid_q <= 1'b1;
        end else begin
          // decay
          rem_q <= EW'(ten_d);
          run_q <= 1'b1;
        end
      end else begin
        env_q   <= hts_pkg::Q15_ONE;
        valid_q <= 1'b1;
      end
    end else if (run_q) begin
      rem_q <= fits ? EW'(rem2 - {1'b0, n_q}) : EW'(rem2);
      quo_q <= {quo_q[hts_pkg::DIV_STEPS-2:0], fits};
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LAST) begin
        run_q   <= 1'b0;
        valid_q <= 1'b1;
        env_q   <= {1'b0, quo_q[hts_pkg::DIV_STEPS-2:0], fits};
      end
    end
  end

  assign valid_o = valid_q;
  assign env_o   = env_q;

endmodule

`default_nettype wire
